// ===== design/sobel_nms_band_threshold_core_defines.svh =====
// Assertion macros shared by the edge detector RTL
`ifndef SOBEL_NMS_BAND_THRESHOLD_CORE_DEFINES_SVH
`define SOBEL_NMS_BAND_THRESHOLD_CORE_DEFINES_SVH

// Clocked property with reset disable
`define SNBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form
`define SNBT_ASSERT_IMP(lbl, ante, cons, msg) \
  `SNBT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/snbt_pkg.sv =====
// Package: constants, types and helpers of the Sobel/NMS edge detector
`default_nettype none
package snbt_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int HEIGHT_LIMIT  = 2048;
  localparam int MIN_SIZE      = 3;

  localparam logic [11:0] WIDTH_RST = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [7:0]  LOW_RST   = 8'd150;
  localparam logic [7:0]  HIGH_RST  = 8'd150;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LOW    = 2'd2;
  localparam logic [1:0] REG_HIGH   = 2'd3;

  localparam logic [1:0] DIR_0   = 2'd0;
  localparam logic [1:0] DIR_45  = 2'd1;
  localparam logic [1:0] DIR_90  = 2'd2;
  localparam logic [1:0] DIR_135 = 2'd3;

  localparam logic [27:0] TAN22_Q16 = 28'd26478;
  localparam logic [27:0] TAN67_Q16 = 28'd154391;
  localparam logic [27:0] TAN68_Q16 = 28'd162207;

  localparam logic [7:0] EDGE_ON = 8'd255;
  localparam logic [7:0] MAG_SAT = 8'd255;

  typedef struct packed {
    logic valid;
    logic eof;
    logic interior;
  } pos_t;

  typedef struct packed {
    logic [10:0] rem;
    logic [7:0]  root;
  } sq_st_t;

  // one digit of a restoring square root
  function automatic sq_st_t sqrt_step(input sq_st_t st, input logic [1:0] pr);
    sq_st_t      nx;
    logic [10:0] rn;
    logic [10:0] tr;
    rn = {st.rem[8:0], pr};
    tr = {1'b0, st.root, 2'b01};
    if (rn >= tr) begin
      nx.rem  = rn - tr;
      nx.root = {st.root[6:0], 1'b1};
    end else begin
      nx.rem  = rn;
      nx.root = {st.root[6:0], 1'b0};
    end
    return nx;
  endfunction

endpackage
`default_nettype wire

// ===== design/snbt_ram.sv =====
// Simple dual-port line buffer memory with registered read
`default_nettype none
module snbt_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]                 rdata_o
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== design/snbt_gradient.sv =====
// Pixel window, Sobel gradient, magnitude and direction pipeline (6 stages)
`default_nettype none
module snbt_gradient (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] top_i,
  input  wire logic [7:0] mid_i,
  input  wire logic [7:0] px_i,
  output logic [7:0]      mag_o,
  output logic [1:0]      dir_o
);
  import snbt_pkg::*;

  logic [7:0] win_q [9];

  logic signed [10:0] gx_d, gy_d, gx_q, gy_q;
  logic [9:0]  ax_q, ay_q;
  logic [19:0] sqx_q, sqy_q;
  logic        gxz_q, same_q;
  logic [20:0] sum_q;
  logic [7:0]  sum6_q;
  logic [1:0]  dir5_q, dir6_q, dir_q;
  logic [1:0]  dir_d;
  sq_st_t      st6_d, st6_q, st7_d;
  logic        sat6_q;
  logic [7:0]  mag_q;
  logic [27:0] lhs, p22, p67, p68;
  logic [9:0]  ax_d, ay_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (en_i && shift_i) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= top_i;
      win_q[5] <= mid_i;
      win_q[8] <= px_i;
    end
  end

  always_comb begin
    gx_d = $signed({1'b0, {2'b0, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b0, win_q[8]}})
         - $signed({1'b0, {2'b0, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b0, win_q[6]}});
    gy_d = $signed({1'b0, {2'b0, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b0, win_q[2]}})
         - $signed({1'b0, {2'b0, win_q[6]} + {1'b0, win_q[7], 1'b0} + {2'b0, win_q[8]}});
    ax_d = gx_q[10] ? 10'(-gx_q) : gx_q[9:0];
    ay_d = gy_q[10] ? 10'(-gy_q) : gy_q[9:0];
  end

  always_comb begin
    lhs = {2'b0, ay_q, 16'b0};
    p22 = 28'(ax_q) * TAN22_Q16;
    p67 = 28'(ax_q) * TAN67_Q16;
    p68 = 28'(ax_q) * TAN68_Q16;
    if (gxz_q) begin
      dir_d = DIR_0;
    end else if (same_q) begin
      if (lhs <= p22) dir_d = DIR_0;
      else if (lhs <= p67) dir_d = DIR_45;
      else dir_d = DIR_90;
    end else begin
      dir_d = (lhs >= p68) ? DIR_90 : DIR_135;
    end
  end

  always_comb begin
    st6_d = '0;
    for (int i = 7; i >= 4; i--) st6_d = sqrt_step(st6_d, sum_q[2*i +: 2]);
    st7_d = st6_q;
    for (int i = 3; i >= 0; i--) st7_d = sqrt_step(st7_d, sum6_q[2*i +: 2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      sqx_q  <= ax_d * ax_d;
      sqy_q  <= ay_d * ay_d;
      gxz_q  <= (gx_q == '0);
      same_q <= (gy_q == '0) || (gx_q[10] == gy_q[10]);
      sum_q  <= {1'b0, sqx_q} + {1'b0, sqy_q};
      dir5_q <= dir_d;
      st6_q  <= st6_d;
      sum6_q <= sum_q[7:0];
      sat6_q <= |sum_q[20:16];
      dir6_q <= dir5_q;
      mag_q  <= sat6_q ? MAG_SAT : st7_d.root;
      dir_q  <= dir6_q;
    end
  end

  assign mag_o = mag_q;
  assign dir_o = dir_q;
endmodule
`default_nettype wire

// ===== design/snbt_nms.sv =====
// Magnitude window, direction delay, suppression and band threshold
`default_nettype none
module snbt_nms (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] mtop_i,
  input  wire logic [7:0] mmid_i,
  input  wire logic [7:0] mnew_i,
  input  wire logic [1:0] dold_i,
  input  wire logic [7:0] low_i,
  input  wire logic [7:0] high_i,
  output logic [7:0]      thin_o,
  output logic [7:0]      edge_o,
  output logic [1:0]      cdir_o
);
  import snbt_pkg::*;

  logic [7:0] win_q [9];
  logic [1:0] ddly_q, cdir_q;
  logic [7:0] a, b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
      ddly_q <= DIR_0;
      cdir_q <= DIR_0;
    end else if (en_i && shift_i) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= mtop_i;
      win_q[5] <= mmid_i;
      win_q[8] <= mnew_i;
      cdir_q   <= ddly_q;
      ddly_q   <= dold_i;
    end
  end

  always_comb begin
    unique case (cdir_q)
      DIR_0:   begin a = win_q[3]; b = win_q[5]; end
      DIR_45:  begin a = win_q[8]; b = win_q[0]; end
      DIR_90:  begin a = win_q[1]; b = win_q[7]; end
      DIR_135: begin a = win_q[2]; b = win_q[6]; end
      default: begin a = '0; b = '0; end
    endcase
    thin_o = (win_q[4] > a && win_q[4] > b) ? win_q[4] : '0;
    edge_o = (thin_o > low_i && thin_o < high_i) ? EDGE_ON : '0;
  end

  assign cdir_o = cdir_q;
endmodule
`default_nettype wire

// ===== design/sobel_nms_band_threshold_core.sv =====
// Top level: config port, raster counters, line buffers and stage control
// Sobel edge detector with non-maximum suppression and band threshold. Takes one
// pixel per clock and gives one result per pixel, ten register stages from input
// to output; the whole pipeline stalls together while the output is held. The
// result for the pixel at raster index n names position n-(2*width+2). After
// reset a clearing pass zeroes all MAX_WIDTH addresses of both line buffers; no
// pixel is taken meanwhile.
`default_nettype none
`include "sobel_nms_band_threshold_core_defines.svh"
module sobel_nms_band_threshold_core #(
  parameter int MAX_WIDTH = snbt_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  wire logic [0:0]  s_axis_tuser,   // [0] start_of_frame
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] edge_res, [15:8] thinned_magnitude,
                                           // [17:16] direction, zero above
  output logic [0:0]       m_axis_tuser,   // [0] position_valid
  output logic             m_axis_tlast    // end_of_frame
);
  import snbt_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(HEIGHT_LIMIT);
  localparam int PW = ((CW > 11) ? CW : 11) + 3;

  logic [11:0] width_q, height_q;
  logic [7:0]  low_q, high_q;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      low_q    <= LOW_RST;
      high_q   <= HIGH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[11:0];
        REG_HEIGHT: height_q <= pwdata[11:0];
        REG_LOW:    low_q    <= pwdata[7:0];
        REG_HIGH:   high_q   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {20'b0, width_q};
      REG_HEIGHT: prdata = {20'b0, height_q};
      REG_LOW:    prdata = {24'b0, low_q};
      REG_HIGH:   prdata = {24'b0, high_q};
      default:    prdata = '0;
    endcase
  end

  // clamped frame size
  logic signed [PW-1:0] wc, hc, iw, ih;
  always_comb begin
    iw = PW'(width_q);
    ih = PW'(height_q);
    if (iw < PW'(MIN_SIZE)) wc = PW'(MIN_SIZE);
    else if (iw > PW'(MAX_WIDTH)) wc = PW'(MAX_WIDTH);
    else wc = iw;
    if (ih < PW'(MIN_SIZE)) hc = PW'(MIN_SIZE);
    else if (ih > PW'(HEIGHT_LIMIT)) hc = PW'(HEIGHT_LIMIT);
    else hc = ih;
  end

  // clearing pass
  logic          clr_busy_q;
  logic [CW-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CW'(MAX_WIDTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  logic en, acc;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en && !clr_busy_q;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // raster counters
  logic [CW-1:0] col_q, c_use;
  logic [RW-1:0] row_q, r_use;
  logic          tail_q, tail_use;
  always_comb begin
    c_use    = s_axis_tuser[0] ? '0 : col_q;
    r_use    = s_axis_tuser[0] ? '0 : row_q;
    tail_use = (s_axis_tuser[0] && (row_q != '0 || col_q != '0)) ? 1'b0 : tail_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      tail_q <= 1'b0;
    end else if (acc) begin
      tail_q <= tail_use;
      if (PW'(c_use) + PW'(1) < wc) begin
        col_q <= c_use + 1'b1;
        row_q <= r_use;
      end else begin
        col_q <= '0;
        if (PW'(r_use) + PW'(1) < hc) begin
          row_q <= r_use + 1'b1;
        end else begin
          row_q  <= '0;
          tail_q <= 1'b1;
        end
      end
    end
  end

  // stage 1
  logic          s1_vld_q, s1_tail_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic [7:0]    s1_px_q;
  logic [15:0]   pix_rd;
  logic          fwd_q;
  logic [15:0]   fwd_wd_q, pix_rd_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en) s1_vld_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_col_q  <= c_use;
      s1_row_q  <= r_use;
      s1_tail_q <= tail_use;
      s1_px_q   <= s_axis_tdata;
    end
  end

  // column written and read at the same edge: take the written data
  assign pix_rd_eff = fwd_q ? fwd_wd_q : pix_rd;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fwd_q <= 1'b0;
    else if (en) fwd_q <= s1_vld_q && (c_use == s1_col_q);
  end
  always_ff @(posedge clk_i) begin
    if (en) fwd_wd_q <= {pix_rd_eff[7:0], s1_px_q};
  end

  logic          pix_we;
  logic [CW-1:0] pix_wa;
  logic [15:0]   pix_wd;
  assign pix_we = clr_busy_q || (en && s1_vld_q);
  assign pix_wa = clr_busy_q ? clr_cnt_q : s1_col_q;
  assign pix_wd = clr_busy_q ? '0 : {pix_rd_eff[7:0], s1_px_q};

  snbt_ram #(.DW(16), .DEPTH(MAX_WIDTH)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_wa),
    .wdata_i (pix_wd),
    .re_i    (en),
    .raddr_i (c_use),
    .rdata_o (pix_rd)
  );

  // output position of this item
  pos_t                 pos_d;
  logic signed [PW-1:0] py, px;
  always_comb begin
    if (s1_col_q >= CW'(2)) begin
      py = PW'(s1_row_q) - PW'(2);
      px = PW'(s1_col_q) - PW'(2);
    end else begin
      py = PW'(s1_row_q) - PW'(3);
      px = PW'(s1_col_q) - PW'(2) + wc;
    end
    pos_d = '0;
    if (py < 0) begin
      if (s1_tail_q) begin
        pos_d.valid = 1'b1;
        pos_d.eof   = (py + hc == hc - PW'(1)) && (px == wc - PW'(1));
      end
    end else if (py < hc && px < wc) begin
      pos_d.valid    = 1'b1;
      pos_d.eof      = (py == hc - PW'(1)) && (px == wc - PW'(1));
      pos_d.interior = (py >= PW'(2)) && (py <= hc - PW'(3))
                    && (px >= PW'(2)) && (px <= wc - PW'(3));
    end
  end

  // stages 2..7 tags alongside the gradient unit
  logic          tvld_q [7:2];
  logic [CW-1:0] tcol_q [7:2];
  pos_t          tpos_q [7:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 2; i <= 7; i++) tvld_q[i] <= 1'b0;
    end else if (en) begin
      tvld_q[2] <= s1_vld_q;
      for (int i = 3; i <= 7; i++) tvld_q[i] <= tvld_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tcol_q[2] <= s1_col_q;
      tpos_q[2] <= pos_d;
      for (int i = 3; i <= 7; i++) begin
        tcol_q[i] <= tcol_q[i-1];
        tpos_q[i] <= tpos_q[i-1];
      end
    end
  end

  logic [7:0] mag7;
  logic [1:0] dir7;
  snbt_gradient u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .shift_i (s1_vld_q),
    .top_i   (pix_rd_eff[15:8]),
    .mid_i   (pix_rd_eff[7:0]),
    .px_i    (s1_px_q),
    .mag_o   (mag7),
    .dir_o   (dir7)
  );

  // stage 8: magnitude line read
  logic          s8_vld_q, s8_cge_q;
  logic [CW-1:0] s8_col_q;
  pos_t          s8_pos_q;
  logic [7:0]    s8_mag_q;
  logic [1:0]    s8_dir_q;
  logic [17:0]   mag_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s8_vld_q <= 1'b0;
    else if (en) s8_vld_q <= tvld_q[7];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_col_q <= tcol_q[7];
      s8_cge_q <= (tcol_q[7] != '0);
      s8_pos_q <= tpos_q[7];
      s8_mag_q <= mag7;
      s8_dir_q <= dir7;
    end
  end

  logic          mag_we;
  logic [CW-1:0] mag_wa;
  logic [17:0]   mag_wd;
  assign mag_we = clr_busy_q || (en && s8_vld_q && s8_cge_q);
  assign mag_wa = clr_busy_q ? clr_cnt_q : s8_col_q - 1'b1;
  assign mag_wd = clr_busy_q ? '0 : {mag_rd[9:2], s8_mag_q, s8_dir_q};

  snbt_ram #(.DW(18), .DEPTH(MAX_WIDTH)) u_mag_ram (
    .clk_i   (clk_i),
    .we_i    (mag_we),
    .waddr_i (mag_wa),
    .wdata_i (mag_wd),
    .re_i    (en),
    .raddr_i (tcol_q[7] - 1'b1),
    .rdata_o (mag_rd)
  );

  // stage 9: magnitude window
  logic s9_vld_q;
  pos_t s9_pos_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s9_vld_q <= 1'b0;
    else if (en) s9_vld_q <= s8_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) s9_pos_q <= s8_pos_q;
  end

  logic [7:0] thin, edge_v;
  logic [1:0] cdir;
  snbt_nms u_nms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .shift_i (s8_vld_q),
    .mtop_i  (s8_cge_q ? mag_rd[17:10] : 8'd0),
    .mmid_i  (s8_cge_q ? mag_rd[9:2] : 8'd0),
    .mnew_i  (s8_cge_q ? s8_mag_q : 8'd0),
    .dold_i  (s8_cge_q ? mag_rd[1:0] : DIR_0),
    .low_i   (low_q),
    .high_i  (high_q),
    .thin_o  (thin),
    .edge_o  (edge_v),
    .cdir_o  (cdir)
  );

  // stage 10: output register
  logic [7:0] edge_q, thin_q;
  logic [1:0] odir_q;
  logic       pvld_q, eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= s9_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pvld_q <= s9_pos_q.valid;
      eof_q  <= s9_pos_q.eof;
      edge_q <= s9_pos_q.interior ? edge_v : '0;
      thin_q <= s9_pos_q.interior ? thin : '0;
      odir_q <= s9_pos_q.interior ? cdir : DIR_0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, odir_q, thin_q, edge_q};
  assign m_axis_tuser  = pvld_q;
  assign m_axis_tlast  = eof_q;

  `SNBT_ASSERT_IMP(a_no_take_clear, clr_busy_q, !s_axis_tready, "pixel taken during clear")
  `SNBT_ASSERT_IMP(a_eof_valid, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0],
                   "end of frame on invalid position")
  `SNBT_ASSERT_IMP(a_thin_valid, m_axis_tvalid && thin_q != 8'd0, pvld_q,
                   "magnitude on invalid position")
  `SNBT_ASSERT_IMP(a_edge_band, m_axis_tvalid && edge_q != 8'd0,
                   edge_q == EDGE_ON && thin_q > low_q && thin_q < high_q,
                   "edge outside band")
endmodule
`default_nettype wire
